[hw/rtl/rolling_realized_volatility_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rolling realized volatility block
// Shared property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ROLLING_REALIZED_VOLATILITY_MACROS_SVH
`define ROLLING_REALIZED_VOLATILITY_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RRV_ASSERT_IMPL(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequence is checked in the next cycle.
`define RRV_ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/rrv_pkg.sv]
// ----------------------------------------------------------------------------
// Rolling realized volatility package
// Request and result types and fixed constants.
// ----------------------------------------------------------------------------
package rrv_pkg;
	typedef struct packed {
		logic [31:0] best_bid;
		logic [31:0] best_ask;
		logic [15:0] update_id;
	} rrv_in_t;

	typedef struct packed {
		logic [25:0] volatility;
		logic        vol_valid;
	} rrv_out_t;

	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
	localparam logic [25:0] VOL_MAX = 26'h3FFFFFF;
	localparam int LOG_FRAC_BITS = 24;
endpackage

[hw/rtl/rolling_realized_volatility.sv]
// A request runs through the log squaring loop, the restoring divide and the root, plus an
// eviction for each ring entry that leaves (one when the window is full). Special cases
// finish sooner: zero price, first update, zero spacing sum and zero quotient.
// Only one request is in work at a time; the next can be taken once the previous result is registered.
// Reset: arst_n clears the state register, history, sums, ring pointers and output valid,
// and sets the window length to 256.
// ----------------------------------------------------------------------------
// Rolling realized volatility
// Log returns of the summed top of book, squared and kept in a ring memory
// with running sums; the result is sqrt(sum sq / sum spacing) in Q6.20.
// ----------------------------------------------------------------------------
module rolling_realized_volatility #(
	parameter int WINDOW_DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  rrv_pkg::rrv_in_t         in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output rrv_pkg::rrv_out_t        out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [8:0]               cfg_data
);
	import rrv_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

	// The controller walks through: normalize, log squaring loop, scale,
	// difference, ring eviction (read then subtract), push, divide, root, and output.
	typedef enum logic [3:0] {
		ST_IDLE, ST_NORM, ST_SQ_MUL, ST_SQ_LO, ST_SQ_FIN, ST_LN_MUL, ST_LN_FIN,
		ST_DIFF, ST_EVICT_RD, ST_EVICT_SUB, ST_PUSH, ST_DIV, ST_ROOT, ST_OUT
	} state_t;

	state_t          state_q;
	logic [32:0]     sum_q;
	logic [15:0]     id_q;
	logic [5:0]      k_q;
	logic [31:0]     x_q;
	logic [63:0]     prod_q;
	logic [23:0]     frac_q;
	logic [4:0]      step_q;
	logic [25:0]     lg_q;
	logic [25:0]     last_log_q;
	logic [15:0]     last_id_q;
	logic            primed_q;
	logic [51:0]     sq_q;
	logic [15:0]     sp_q;
	logic [59:0]     sq_sum_q;
	logic [23:0]     sp_sum_q;
	logic [CW-1:0]   fill_q;
	logic [AW-1:0]   head_q;
	logic [8:0]      win_cfg_q;
	logic [25:0]     held_q;
	logic [59:0]     quo_q;
	logic [23:0]     rem_q;
	logic [5:0]      div_cnt_q;
	logic [59:0]     rad_q;
	logic [31:0]     root_q;
	logic [33:0]     racc_q;
	logic [4:0]      root_cnt_q;
	rrv_out_t        res_q;
	rrv_out_t        out_q;
	logic            out_valid_q;

	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [51:0]     sq_rdata;
	logic [15:0]     sp_rdata;

	logic [CW-1:0]   win_eff;
	logic [CW-1:0]   cfg_ext;
	logic [24:0]     rem_shift;
	logic [33:0]     racc_shift;
	logic [33:0]     rtrial;
	logic [5:0]      k_next;
	logic [AW:0]     push_sum;

	rrv_ram #(.WIDTH(52), .DEPTH(WINDOW_DEPTH)) u_sq_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(sq_q), .rdata(sq_rdata)
	);
	rrv_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_sp_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(sp_q), .rdata(sp_rdata)
	);

	// Clamp the window register into 1..WINDOW_DEPTH.
	always_comb begin
		cfg_ext = (CW > 9) ? CW'(win_cfg_q) : CW'(win_cfg_q);
		if (win_cfg_q == 9'd0) begin
			win_eff = CW'(1);
		end else if ((CW < 10) && (win_cfg_q > 9'(WINDOW_DEPTH))) begin
			win_eff = DEPTH_C;
		end else if (cfg_ext > DEPTH_C) begin
			win_eff = DEPTH_C;
		end else begin
			win_eff = cfg_ext;
		end
	end

	// Push lands at head plus fill, wrapping around the ring.
	always_comb begin
		push_sum = {1'b0, head_q} + fill_q[AW:0];
		if (push_sum >= (AW+1)'(WINDOW_DEPTH)) begin
			push_sum = push_sum - (AW+1)'(WINDOW_DEPTH);
		end
	end

	assign ram_we   = (state_q == ST_PUSH);
	assign ram_addr = (state_q == ST_PUSH) ? push_sum[AW-1:0] : head_q;

	// Combinational leading one search over the 33-bit sum.
	always_comb begin
		k_next = '0;
		for (int i = 0; i < 33; i++) begin
			if (sum_q[i]) begin
				k_next = 6'(i);
			end
		end
	end

	assign rem_shift  = {rem_q, quo_q[59]};
	assign racc_shift = {racc_q[31:0], rad_q[59:58]};
	assign rtrial     = {root_q, 2'b01};

	// A window write never shares an edge with an accepted request, so the
	// new length always applies from the next request on.
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_log_q  <= '0;
			last_id_q   <= '0;
			primed_q    <= 1'b0;
			sq_sum_q    <= '0;
			sp_sum_q    <= '0;
			fill_q      <= '0;
			head_q      <= '0;
			win_cfg_q   <= 9'd256;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				win_cfg_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sum_q <= {1'b0, in_data.best_bid} + {1'b0, in_data.best_ask};
						id_q  <= in_data.update_id;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (sum_q == '0) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						k_q <= k_next;
						if (k_next <= 6'd30) begin
							x_q <= 32'(sum_q << (6'd30 - k_next));
						end else begin
							x_q <= 32'(sum_q >> (k_next - 6'd30));
						end
						frac_q  <= '0;
						step_q  <= '0;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQ_MUL: begin
					prod_q  <= 64'(x_q) * 64'(x_q);
					state_q <= ST_SQ_FIN;
				end
				ST_SQ_FIN: begin
					if (prod_q[61]) begin
						x_q    <= 32'(prod_q >> 31);
						frac_q <= {frac_q[22:0], 1'b1};
					end else begin
						x_q    <= 32'(prod_q >> 30);
						frac_q <= {frac_q[22:0], 1'b0};
					end
					step_q <= step_q + 5'd1;
					state_q <= (step_q == 5'(LOG_FRAC_BITS - 1)) ? ST_LN_MUL : ST_SQ_MUL;
				end
				ST_LN_MUL: begin
					// The integer part of log2 reaches 32, so all six bits of k count.
					prod_q  <= 64'({k_q, frac_q}) * 64'(LN2_Q32) + 64'h8_0000_0000;
					state_q <= ST_LN_FIN;
				end
				ST_LN_FIN: begin
					lg_q <= 26'(prod_q >> 36);
					if (!primed_q) begin
						primed_q   <= 1'b1;
						last_log_q <= 26'(prod_q >> 36);
						last_id_q  <= id_q;
						res_q      <= '0;
						state_q    <= ST_OUT;
					end else begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					sq_q <= (lg_q >= last_log_q)
						? 52'((lg_q - last_log_q) * (lg_q - last_log_q))
						: 52'((last_log_q - lg_q) * (last_log_q - lg_q));
					sp_q <= id_q - last_id_q;
					state_q <= ST_EVICT_RD;
				end
				ST_EVICT_RD: begin
					if (fill_q >= win_eff) begin
						state_q <= ST_EVICT_SUB;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_EVICT_SUB: begin
					sq_sum_q <= sq_sum_q - 60'(sq_rdata);
					sp_sum_q <= sp_sum_q - 24'(sp_rdata);
					head_q   <= (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);
					fill_q   <= fill_q - CW'(1);
					state_q  <= ST_EVICT_RD;
				end
				ST_PUSH: begin
					fill_q     <= fill_q + CW'(1);
					sq_sum_q   <= sq_sum_q + 60'(sq_q);
					sp_sum_q   <= sp_sum_q + 24'(sp_q);
					last_log_q <= lg_q;
					last_id_q  <= id_q;
					quo_q      <= sq_sum_q + 60'(sq_q);
					rem_q      <= '0;
					div_cnt_q  <= '0;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					// Restoring divide, one quotient bit a cycle.
					if (sp_sum_q == '0) begin
						held_q  <= '0;
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						if (rem_shift >= {1'b0, sp_sum_q}) begin
							rem_q <= 24'(rem_shift - {1'b0, sp_sum_q});
							quo_q <= {quo_q[58:0], 1'b1};
						end else begin
							rem_q <= rem_shift[23:0];
							quo_q <= {quo_q[58:0], 1'b0};
						end
						div_cnt_q <= div_cnt_q + 6'd1;
						if (div_cnt_q == 6'd59) begin
							rad_q      <= '0;
							racc_q     <= '0;
							root_q     <= '0;
							root_cnt_q <= '0;
							state_q    <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					// Digit-by-digit square root, two radicand bits a cycle.
					if (root_cnt_q == 5'd0 && rad_q == '0 && racc_q == '0
						&& root_q == '0) begin
						rad_q <= quo_q;
					end
					if (rad_q != '0 || root_cnt_q != 5'd0) begin
						if (racc_shift >= rtrial) begin
							racc_q <= racc_shift - rtrial;
							root_q <= {root_q[30:0], 1'b1};
						end else begin
							racc_q <= racc_shift;
							root_q <= {root_q[30:0], 1'b0};
						end
						rad_q      <= {rad_q[57:0], 2'b00};
						root_cnt_q <= root_cnt_q + 5'd1;
						if (root_cnt_q == 5'd29) begin
							state_q <= ST_OUT;
							res_q.vol_valid <= 1'b1;
						end
					end else if (quo_q == '0) begin
						held_q  <= '0;
						res_q   <= '{volatility: '0, vol_valid: 1'b1};
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// The working result moves to the output register only once the
					// previous result has been taken.
					if (res_q.vol_valid && root_cnt_q == 5'd30) begin
						res_q.volatility <= (root_q[31:26] != '0) ? VOL_MAX : root_q[25:0];
						held_q <= (root_q[31:26] != '0) ? VOL_MAX : root_q[25:0];
						root_cnt_q <= '0;
					end else if (!out_valid_q) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						root_cnt_q  <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[hw/rtl/rrv_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rrv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[hw/rtl/rrv_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the rolling realized volatility block
// Watches the handshakes and result codes at the top-level ports.
// ----------------------------------------------------------------------------
`include "rolling_realized_volatility_macros.svh"
module rrv_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input rrv_pkg::rrv_out_t out_data,
	input logic              cfg_ready
);
	import rrv_pkg::*;

	// A result holds until it is taken.
	`RRV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// An invalid result always carries zero.
	`RRV_ASSERT_IMPL(a_invalid_zero, clk, arst_n, out_valid && !out_data.vol_valid, out_data.volatility == '0)
	// An accepted request is never followed by another acceptance the next cycle.
	`RRV_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	// Configuration is taken only while no request is in work.
	`RRV_ASSERT_IMPL(a_cfg_idle, clk, arst_n, cfg_ready, in_ready)
endmodule

bind rolling_realized_volatility rrv_checker u_rrv_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
	.cfg_ready(cfg_ready)
);
